// File: rtl/lrn_channel_window_scale_top_defines.svh
// assertion macros, used by the request queue
`ifndef LRN_CHANNEL_WINDOW_SCALE_TOP_DEFINES_SVH
`define LRN_CHANNEL_WINDOW_SCALE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define LCWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LCWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LCWS_ASSERT(lbl, prop, msg)
`define LCWS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/lcws_pkg.sv
`default_nettype none

package lcws_pkg;

  localparam int CNT_W       = 13;
  localparam int SUM_W       = 34;
  localparam int SQ_W        = 31;
  localparam int CHAN_W      = 12;
  localparam int SCALE_W     = 36;
  localparam int SAMPLE_W    = 16;
  localparam int WS_W        = 4;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K_OFFSET      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_NORM    = 2'd3;

  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 13'd64;
  localparam logic [WS_W-1:0]  WINDOW_SIZE_RST   = 4'd5;
  localparam logic [31:0]      K_OFFSET_RST      = 32'd65536;
  localparam logic [31:0]      ALPHA_NORM_RST    = 32'd85899;

  typedef struct packed {
    logic [CNT_W-1:0] channel_count;
    logic [WS_W-1:0]  window_size;
    logic [31:0]      k_offset;
    logic [31:0]      alpha_norm;
  } lcws_cfg_t;

  // one pending scale computation
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CHAN_W-1:0] chan;
    logic              done;
  } lcws_req_t;

  typedef enum logic {
    FRONT_RUN,
    FRONT_FLUSH
  } lcws_front_state_e;

endpackage

`default_nettype wire

// File: rtl/lcws_front.sv
`default_nettype none

module lcws_front #(
  parameter int WINDOW_MAX   = 15,
  parameter int MAX_CHANNELS = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lcws_pkg::lcws_cfg_t                  cfg_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [lcws_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                      push_o,
  output lcws_pkg::lcws_req_t                       push_data_o,
  input  wire logic                                 full_i
);

  localparam int CntW   = lcws_pkg::CNT_W;
  localparam int SumW   = lcws_pkg::SUM_W;
  localparam int SqW    = lcws_pkg::SQ_W;
  localparam int SlotW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int MaxW   = $clog2(MAX_CHANNELS + 1);
  localparam int CcW    = (MaxW > CntW) ? MaxW + 1 : CntW + 1;
  localparam int SlotCw = 6;

  lcws_pkg::lcws_front_state_e state_q, state_d;

  logic                 sq_valid_q;
  logic [SqW-1:0]       sq_q;
  logic [SqW-1:0]       hist_q [WINDOW_MAX];
  logic [SumW-1:0]      sum_q, sum_d, sum_upd;
  logic [CntW-1:0]      cnt_q, cnt_d, end_q, end_d;
  logic [SlotW-1:0]     slot_q, slot_d, slot_inc, sub_slot;

  logic [15:0]          mag;
  logic [31:0]          sq_full;
  logic [3:0]           ws_eff;
  logic [3:0]           pp;
  logic [CcW-1:0]       cc_eff;
  logic                 last;
  logic [SlotCw-1:0]    wr6, ws6, sub6;
  logic [SqW-1:0]       sub_val;
  logic                 run_take, flush_step, col_end, emit;

  // square of the sample, most negative value squares to 2^30
  assign mag     = sample_i[15] ? (~sample_i + 16'd1) : sample_i;
  assign sq_full = 32'(mag) * 32'(mag);

  always_comb begin
    if (cfg_i.window_size == '0) begin
      ws_eff = 4'd1;
    end else if (32'(cfg_i.window_size) > WINDOW_MAX) begin
      ws_eff = 4'(WINDOW_MAX);
    end else begin
      ws_eff = cfg_i.window_size;
    end
    pp = ws_eff >> 1;

    if (cfg_i.channel_count == '0) begin
      cc_eff = CcW'(1);
    end else if (32'(cfg_i.channel_count) > MAX_CHANNELS) begin
      cc_eff = CcW'(MAX_CHANNELS);
    end else begin
      cc_eff = CcW'(cfg_i.channel_count);
    end
    last = (CcW'(cnt_q) + CcW'(1)) >= cc_eff;

    // slot of the channel leaving the window, (cnt - ws) mod WINDOW_MAX
    wr6  = SlotCw'(slot_q);
    ws6  = SlotCw'(ws_eff);
    sub6 = (wr6 >= ws6) ? (wr6 - ws6) : (wr6 + SlotCw'(WINDOW_MAX) - ws6);
    sub_slot = sub6[SlotW-1:0];
    sub_val  = (cnt_q >= CntW'(ws_eff)) ? hist_q[sub_slot] : '0;

    slot_inc = (slot_q == SlotW'(WINDOW_MAX - 1)) ? '0 : slot_q + SlotW'(1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcws_pkg::FRONT_RUN: begin
        if (run_take && last && (pp != '0)) state_d = lcws_pkg::FRONT_FLUSH;
      end
      lcws_pkg::FRONT_FLUSH: begin
        if (flush_step && col_end) state_d = lcws_pkg::FRONT_RUN;
      end
    endcase
  end

  // outputs
  always_comb begin
    run_take   = (state_q == lcws_pkg::FRONT_RUN) && sq_valid_q && !full_i;
    flush_step = (state_q == lcws_pkg::FRONT_FLUSH) && !full_i;
    col_end    = (cnt_q == end_q);
    in_ready_o = !sq_valid_q || run_take;
    emit       = cnt_q >= CntW'(pp);
    push_o     = (run_take || flush_step) && emit;
    push_data_o.sum  = sum_upd;
    push_data_o.chan = lcws_pkg::CHAN_W'(cnt_q - CntW'(pp));
    push_data_o.done = run_take ? (last && (pp == '0)) : col_end;
  end

  // window sum and channel position
  always_comb begin
    sum_upd = sum_q - SumW'(sub_val) + (run_take ? SumW'(sq_q) : '0);
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    slot_d  = slot_q;
    end_d   = end_q;
    priority if (run_take) begin
      if (last && (pp == '0)) begin
        sum_d  = '0;
        cnt_d  = '0;
        slot_d = '0;
      end else begin
        sum_d  = sum_upd;
        cnt_d  = cnt_q + CntW'(1);
        slot_d = slot_inc;
        end_d  = cnt_q + CntW'(pp);
      end
    end else if (flush_step) begin
      if (col_end) begin
        sum_d  = '0;
        cnt_d  = '0;
        slot_d = '0;
      end else begin
        sum_d  = sum_upd;
        cnt_d  = cnt_q + CntW'(1);
        slot_d = slot_inc;
      end
    end else begin
      sum_d = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lcws_pkg::FRONT_RUN;
      sq_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
      slot_q     <= '0;
      end_q      <= '0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) begin
        sq_valid_q <= 1'b1;
      end else if (run_take) begin
        sq_valid_q <= 1'b0;
      end
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      slot_q <= slot_d;
      end_q  <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sq_q <= sq_full[SqW-1:0];
    end
    if (run_take) begin
      hist_q[slot_q] <= sq_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lcws_queue.sv
`default_nettype none

`include "lrn_channel_window_scale_top_defines.svh"

module lcws_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire lcws_pkg::lcws_req_t push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output lcws_pkg::lcws_req_t      pop_data_o,
  output logic                     empty_o
);

  localparam int Depth = lcws_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  lcws_pkg::lcws_req_t entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  `LCWS_ASSERT(a_no_push_full, !(push_i && full_o), "request pushed into full queue")
  `LCWS_ASSERT(a_no_pop_empty, !(pop_i && empty_o), "request popped from empty queue")
  `LCWS_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + CntW'(1), "queue count did not grow on push")

endmodule

`default_nettype wire

// File: rtl/lcws_back.sv
`default_nettype none

module lcws_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lcws_pkg::lcws_cfg_t cfg_i,
  input  wire logic                empty_i,
  input  wire lcws_pkg::lcws_req_t pop_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [lcws_pkg::SCALE_W-1:0] scale_value_o,
  output logic [lcws_pkg::CHAN_W-1:0]  channel_index_o,
  output logic                     column_done_o
);

  localparam int ScaleW = lcws_pkg::SCALE_W;
  localparam int AccW   = ScaleW + 1;

  logic        a_valid_q;
  logic [63:0] a_prod_q;
  logic [1:0]  a_hi_q;
  logic [lcws_pkg::CHAN_W-1:0] a_chan_q;
  logic        a_done_q;
  logic        a_ready, o_ready;
  logic [AccW-1:0] acc;

  assign o_ready = !out_valid_o || out_ready_i;
  assign a_ready = !a_valid_q || o_ready;
  assign pop_o   = !empty_i && a_ready;

  // hi*alpha + (lo*alpha >> 32) + k, clipped at 36 bits
  assign acc = AccW'(a_hi_q) * AccW'(cfg_i.alpha_norm) + AccW'(a_prod_q[63:32])
             + AccW'(cfg_i.k_offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= pop_o;
      if (o_ready) out_valid_o <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_prod_q <= 64'(pop_data_i.sum[31:0]) * 64'(cfg_i.alpha_norm);
      a_hi_q   <= pop_data_i.sum[33:32];
      a_chan_q <= pop_data_i.chan;
      a_done_q <= pop_data_i.done;
    end
    if (o_ready && a_valid_q) begin
      scale_value_o   <= acc[ScaleW] ? {ScaleW{1'b1}} : acc[ScaleW-1:0];
      channel_index_o <= a_chan_q;
      column_done_o   <= a_done_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lrn_channel_window_scale_top.sv
`default_nettype none

// Cross-channel LRN scale for one pixel column. Samples (signed Q8.8) arrive channel 0
// first; each channel gets one scale (unsigned Q20.16, k + alpha/size * sum of squares
// over the window) tagged with its channel, emitted window_size/2 channels late. The input
// takes one sample per cycle while the request queue has room; after the last sample of a
// column it stalls while the front sequencer flushes the trailing results, one per cycle
// while the queue has room, the last carrying column_done. A result passes the square
// register, loaded on acceptance, then the window update that writes the request queue,
// then a two-stage multiply and add in the back end. A four-entry request queue
// between front and back absorbs output stalls. The user must write registers through the
// cfg port only while no column results are outstanding; the block does not enforce this.
module lrn_channel_window_scale_top #(
  parameter int WINDOW_MAX   = 15,
  parameter int MAX_CHANNELS = 4096
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [lcws_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [lcws_pkg::CFG_W-1:0]             cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [lcws_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [lcws_pkg::SCALE_W-1:0]                scale_value_o,
  output logic [lcws_pkg::CHAN_W-1:0]                 channel_index_o,
  output logic                                        column_done_o
);

  lcws_pkg::lcws_cfg_t cfg_q;
  lcws_pkg::lcws_req_t push_data, pop_data;
  logic                push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= lcws_pkg::CHANNEL_COUNT_RST;
      cfg_q.window_size   <= lcws_pkg::WINDOW_SIZE_RST;
      cfg_q.k_offset      <= lcws_pkg::K_OFFSET_RST;
      cfg_q.alpha_norm    <= lcws_pkg::ALPHA_NORM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lcws_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[lcws_pkg::CNT_W-1:0];
        lcws_pkg::REG_WINDOW_SIZE:   cfg_q.window_size   <= cfg_data_i[lcws_pkg::WS_W-1:0];
        lcws_pkg::REG_K_OFFSET:      cfg_q.k_offset      <= cfg_data_i;
        lcws_pkg::REG_ALPHA_NORM:    cfg_q.alpha_norm    <= cfg_data_i;
        default:                     cfg_q <= cfg_q;
      endcase
    end
  end

  lcws_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  lcws_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  lcws_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (empty),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .scale_value_o  (scale_value_o),
    .channel_index_o(channel_index_o),
    .column_done_o  (column_done_o)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int HIST_DEPTH    = 15;
  localparam int CHAN_LIMIT    = 4096;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 50;
  localparam int PRINT_LIMIT   = 50;
  localparam int CHAN_BITS     = lcws_pkg::CHAN_W;
  localparam int CNT_BITS      = lcws_pkg::CNT_W;

  typedef struct packed {
    logic [lcws_pkg::SCALE_W-1:0] scale;
    logic [lcws_pkg::CHAN_W-1:0]  chan;
    logic                         done;
  } scale_rec_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [lcws_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [lcws_pkg::CFG_W-1:0]           cfg_data_i;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [lcws_pkg::SAMPLE_W-1:0] sample_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic [lcws_pkg::SCALE_W-1:0]         scale_value_o;
  logic [lcws_pkg::CHAN_W-1:0]          channel_index_o;
  logic                                 column_done_o;

  lrn_channel_window_scale_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .scale_value_o  (scale_value_o),
    .channel_index_o(channel_index_o),
    .column_done_o  (column_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // register mirror, updated when the block takes a write
  logic [lcws_pkg::CNT_W-1:0] chan_count_reg = lcws_pkg::CHANNEL_COUNT_RST;
  logic [lcws_pkg::WS_W-1:0]  win_size_reg   = lcws_pkg::WINDOW_SIZE_RST;
  logic [31:0]                k_reg          = lcws_pkg::K_OFFSET_RST;
  logic [31:0]                alpha_reg      = lcws_pkg::ALPHA_NORM_RST;

  // window state of the column in progress
  logic [lcws_pkg::SQ_W-1:0]  square_hist [HIST_DEPTH];
  logic [lcws_pkg::SUM_W-1:0] square_sum  = '0;
  logic [lcws_pkg::CNT_W-1:0] next_chan   = '0;

  scale_rec_t       pending_scales [$];
  logic [15:0]      sample_q       [$];
  int unsigned      n_sent     = 0;
  int unsigned      n_taken    = 0;
  int unsigned      err_count  = 0;
  int unsigned      idle_pct   = 21;
  bit               req_taken  = 1'b0;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  function automatic logic [lcws_pkg::SCALE_W-1:0] scale_of_sum(
      input logic [lcws_pkg::SUM_W-1:0] sum);
    logic [63:0] v;
    v = 64'(sum[33:32]) * 64'(alpha_reg) + ((64'(sum[31:0]) * 64'(alpha_reg)) >> 32)
        + 64'(k_reg);
    return (v > 64'h0000_000F_FFFF_FFFF) ? '1 : v[lcws_pkg::SCALE_W-1:0];
  endfunction

  task automatic push_scale(input int unsigned ch, input bit last_one);
    scale_rec_t rec;
    rec.scale = scale_of_sum(square_sum);
    rec.chan  = CHAN_BITS'(ch);
    rec.done  = last_one;
    pending_scales.push_back(rec);
  endtask

  // expected scales caused by one accepted sample
  task automatic predict_scales(input logic [15:0] smp);
    int unsigned ws, cc, pp, head, h;
    logic [15:0] mag;
    logic [31:0] sq;
    bit          last_ch;
    ws = win_size_reg;
    if (ws == 0) ws = 1;
    if (ws > HIST_DEPTH) ws = HIST_DEPTH;
    cc = chan_count_reg;
    if (cc == 0) cc = 1;
    if (cc > CHAN_LIMIT) cc = CHAN_LIMIT;
    pp = ws / 2;
    head = next_chan;
    mag = smp[15] ? (~smp + 16'd1) : smp;
    sq = mag * mag;
    if (head >= ws) square_sum = square_sum - square_hist[(head - ws) % HIST_DEPTH];
    square_sum = square_sum + sq;
    square_hist[head % HIST_DEPTH] = sq[lcws_pkg::SQ_W-1:0];
    last_ch = (head + 1 >= cc);
    if (head >= pp) push_scale(head - pp, last_ch && pp == 0);
    if (last_ch) begin
      // trailing channels of the column
      for (h = head + 1; h <= head + pp; h++) begin
        if (h >= ws) square_sum = square_sum - square_hist[(h - ws) % HIST_DEPTH];
        if (h >= pp) push_scale(h - pp, h == head + pp);
      end
      square_sum = '0;
      next_chan = '0;
    end else begin
      next_chan = CNT_BITS'(head + 1);
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      req_taken = 1'b0;
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    scale_rec_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lcws_pkg::REG_CHANNEL_COUNT: chan_count_reg = cfg_data_i[lcws_pkg::CNT_W-1:0];
          lcws_pkg::REG_WINDOW_SIZE:   win_size_reg   = cfg_data_i[lcws_pkg::WS_W-1:0];
          lcws_pkg::REG_K_OFFSET:      k_reg          = cfg_data_i;
          lcws_pkg::REG_ALPHA_NORM:    alpha_reg      = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        predict_scales(sample_i);
        n_taken++;
        req_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_scales.size() == 0) begin
          report_mismatch($sformatf("unexpected scale %h for channel %0d",
                                    scale_value_o, channel_index_o));
        end else begin
          want = pending_scales.pop_front();
          if (scale_value_o !== want.scale)
            report_mismatch($sformatf("channel %0d: scale %h, want %h",
                                      want.chan, scale_value_o, want.scale));
          if (channel_index_o !== want.chan)
            report_mismatch($sformatf("channel index %0d, want %0d",
                                      channel_index_o, want.chan));
          if (column_done_o !== want.done)
            report_mismatch($sformatf("channel %0d: column_done %b, want %b",
                                      want.chan, column_done_o, want.done));
        end
      end
    end
  end

  task automatic queue_sample(input logic [15:0] s);
    sample_q.push_back(s);
    n_sent++;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // wait until every request is taken and every scale is back, then let the pipe empty
  task automatic settle();
    do @(negedge clk_i); while (n_taken != n_sent || pending_scales.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [lcws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] cc, input logic [31:0] ws,
                            input logic [31:0] k, input logic [31:0] alpha);
    write_reg(lcws_pkg::REG_CHANNEL_COUNT, cc);
    write_reg(lcws_pkg::REG_WINDOW_SIZE, ws);
    write_reg(lcws_pkg::REG_K_OFFSET, k);
    write_reg(lcws_pkg::REG_ALPHA_NORM, alpha);
  endtask

  initial begin
    int unsigned rnd_items, len, eff, cut;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = lcws_pkg::REG_CHANNEL_COUNT;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    out_ready_i = 1'b0;
    rnd_items   = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // start of a column at the reset register values, then ended by a smaller count
    repeat (16) queue_sample(rand_sample());
    settle();
    write_reg(lcws_pkg::REG_CHANNEL_COUNT, 3);
    queue_sample(rand_sample());
    settle();

    // fewer channels than the window reaches ahead
    set_config(3, 5, lcws_pkg::K_OFFSET_RST, lcws_pkg::ALPHA_NORM_RST);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'hFFFF);
    settle();

    // zero window and zero count act as one, largest k and alpha
    set_config(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_sample(16'h8000);
    queue_sample(16'h7FFF);
    settle();

    // widest window over two channels, zero k and alpha
    set_config(2, 15, 32'h0, 32'h0);
    queue_sample(16'h8000);
    queue_sample(16'h8000);
    settle();

    set_config(4, 2, 32'h1, 32'hFFFF_FFFF);
    queue_sample(16'h0000);
    queue_sample(16'h0001);
    queue_sample(16'hFFFF);
    queue_sample(16'h8000);
    settle();

    // count shrunk below the channel already reached ends the column
    set_config(20, 5, lcws_pkg::K_OFFSET_RST, lcws_pkg::ALPHA_NORM_RST);
    repeat (6) queue_sample(rand_sample());
    settle();
    write_reg(lcws_pkg::REG_CHANNEL_COUNT, 3);
    queue_sample(16'h1234);
    settle();

    // oversized count clamps to the channel limit, no idling on either side
    idle_pct = 0;
    set_config(32'h1FFF, $urandom_range(15), rand_word(), rand_word());
    repeat (32) queue_sample(rand_sample());
    settle();
    write_reg(lcws_pkg::REG_CHANNEL_COUNT, 1);
    queue_sample(rand_sample());
    settle();
    idle_pct = 21;

    while (rnd_items < RANDOM_ITEMS) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
      eff = (len == 0) ? 1 : len;
      set_config(len, $urandom_range(15), rand_word(), rand_word());
      if (eff > 2 && $urandom_range(4) == 0) begin
        cut = $urandom_range(eff - 2, 1);
        repeat (cut) queue_sample(rand_sample());
        settle();
        write_reg(lcws_pkg::REG_CHANNEL_COUNT, $urandom_range(cut));
        queue_sample(rand_sample());
        rnd_items += cut + 1;
      end else begin
        repeat (eff) queue_sample(rand_sample());
        rnd_items += eff;
      end
      settle();
    end

    settle();
    if (err_count == 0 && pending_scales.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
